>>> hw/rtl/hsp_pkg.sv
package hsp_pkg;

    // Width of the version and status accumulators; values saturate at all ones.
    localparam int NUMBER_BITS = 16;
    // Width of the version and status fields on the result channel.
    localparam int OUT_NUM_BITS = 16;
    // Entries in the queue between the parser and the result stage.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS = $clog2(QUEUE_DEPTH + 1);

    // Byte classes.
    localparam logic [2:0] CLASS_OTHER  = 3'd0;
    localparam logic [2:0] CLASS_METHOD = 3'd1;
    localparam logic [2:0] CLASS_URI    = 3'd2;
    localparam logic [2:0] CLASS_NAME   = 3'd3;
    localparam logic [2:0] CLASS_VALUE  = 3'd4;
    localparam logic [2:0] CLASS_CONT   = 3'd5;
    localparam logic [2:0] CLASS_REASON = 3'd6;

    // Message kinds.
    localparam logic [1:0] KIND_UNKNOWN  = 2'd0;
    localparam logic [1:0] KIND_REQUEST  = 2'd1;
    localparam logic [1:0] KIND_RESPONSE = 2'd2;

    // Error codes.
    localparam logic [2:0] ERR_NONE        = 3'd0;
    localparam logic [2:0] ERR_KIND        = 3'd1;
    localparam logic [2:0] ERR_REQUEST     = 3'd2;
    localparam logic [2:0] ERR_HEADER      = 3'd3;
    localparam logic [2:0] ERR_VERSION     = 3'd4;
    localparam logic [2:0] ERR_STATUS      = 3'd5;
    localparam logic [2:0] ERR_STATUS_LINE = 3'd6;

    // Characters of interest.
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;

    // Input request.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       restart;
    } hsp_in_t;

    // Result item.
    typedef struct packed {
        logic [7:0]              byte_value;
        logic [2:0]              byte_class;
        logic                    field_begins;
        logic [1:0]              message_kind;
        logic [OUT_NUM_BITS-1:0] major_version;
        logic [OUT_NUM_BITS-1:0] minor_version;
        logic [OUT_NUM_BITS-1:0] status_code;
        logic                    head_complete;
        logic                    parse_error;
        logic [2:0]              error_kind;
        logic                    last;
    } hsp_out_t;

    // One classified byte as it waits in the queue.
    typedef struct packed {
        logic [7:0]              byte_value;
        logic [2:0]              byte_class;
        logic                    field_begins;
        logic [1:0]              message_kind;
        logic [OUT_NUM_BITS-1:0] major_version;
        logic [OUT_NUM_BITS-1:0] minor_version;
        logic [OUT_NUM_BITS-1:0] status_code;
        logic                    head_complete;
        logic [2:0]              error_kind;
        logic                    held;
        logic                    held_method;
    } hsp_entry_t;

    // Queue status seen by the parser and the result stage.
    typedef struct packed {
        logic empty;
        logic full;
    } hsp_qstat_t;

    // Decimal accumulate with saturation at all ones.
    function automatic logic [NUMBER_BITS-1:0] dec_acc(input logic [NUMBER_BITS-1:0] v,
                                                       input logic [3:0] d);
        logic [NUMBER_BITS+3:0] wide;
        logic [NUMBER_BITS+3:0] r;
        wide = {4'b0000, v};
        r = (wide << 3) + (wide << 1) + {{NUMBER_BITS{1'b0}}, d};
        if (r[NUMBER_BITS+3:NUMBER_BITS] != 4'b0000) begin
            return {NUMBER_BITS{1'b1}};
        end
        return r[NUMBER_BITS-1:0];
    endfunction

endpackage

>>> hw/rtl/hsp_front.sv
module hsp_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  hsp_pkg::hsp_in_t    s_data,
    output logic                push,
    output hsp_pkg::hsp_entry_t push_entry
);

    localparam int PHASE_BITS = 6;
    localparam logic [PHASE_BITS-1:0] PH_TYPE         = 6'd0;
    localparam logic [PHASE_BITS-1:0] PH_TYPECHK      = 6'd1;
    localparam logic [PHASE_BITS-1:0] PH_METHOD       = 6'd2;
    localparam logic [PHASE_BITS-1:0] PH_METHOD_SP    = 6'd3;
    localparam logic [PHASE_BITS-1:0] PH_URI          = 6'd4;
    localparam logic [PHASE_BITS-1:0] PH_URI_SP       = 6'd5;
    localparam logic [PHASE_BITS-1:0] PH_V_H          = 6'd6;
    localparam logic [PHASE_BITS-1:0] PH_V_T1         = 6'd7;
    localparam logic [PHASE_BITS-1:0] PH_V_T2         = 6'd8;
    localparam logic [PHASE_BITS-1:0] PH_V_P          = 6'd9;
    localparam logic [PHASE_BITS-1:0] PH_V_SLASH      = 6'd10;
    localparam logic [PHASE_BITS-1:0] PH_V_MAJOR      = 6'd11;
    localparam logic [PHASE_BITS-1:0] PH_V_MINOR      = 6'd12;
    localparam logic [PHASE_BITS-1:0] PH_REQ_LF       = 6'd13;
    localparam logic [PHASE_BITS-1:0] PH_RESP_SP      = 6'd14;
    localparam logic [PHASE_BITS-1:0] PH_STATUS       = 6'd15;
    localparam logic [PHASE_BITS-1:0] PH_REASON_START = 6'd16;
    localparam logic [PHASE_BITS-1:0] PH_REASON       = 6'd17;
    localparam logic [PHASE_BITS-1:0] PH_RESP_LF      = 6'd18;
    localparam logic [PHASE_BITS-1:0] PH_HDR_START    = 6'd19;
    localparam logic [PHASE_BITS-1:0] PH_CONT_START   = 6'd20;
    localparam logic [PHASE_BITS-1:0] PH_CONT         = 6'd21;
    localparam logic [PHASE_BITS-1:0] PH_NAME         = 6'd22;
    localparam logic [PHASE_BITS-1:0] PH_NAME_END     = 6'd23;
    localparam logic [PHASE_BITS-1:0] PH_VAL_START    = 6'd24;
    localparam logic [PHASE_BITS-1:0] PH_VAL          = 6'd25;
    localparam logic [PHASE_BITS-1:0] PH_HDR_LF       = 6'd26;
    localparam logic [PHASE_BITS-1:0] PH_END_LF       = 6'd27;
    localparam logic [PHASE_BITS-1:0] PH_DONE         = 6'd28;

    // Which number a digit goes into.
    localparam logic [1:0] ACC_NONE  = 2'd0;
    localparam logic [1:0] ACC_MAJOR = 2'd1;
    localparam logic [1:0] ACC_MINOR = 2'd2;
    localparam logic [1:0] ACC_STAT  = 2'd3;

    // Longest chain of phases one byte can pass through.
    localparam int MAX_STEPS = 4;

    logic [PHASE_BITS-1:0]           phase_reg, phase_next;
    logic [1:0]                      kind_reg, kind_next;
    logic [hsp_pkg::NUMBER_BITS-1:0] major_reg, major_next;
    logic [hsp_pkg::NUMBER_BITS-1:0] minor_reg, minor_next;
    logic [hsp_pkg::NUMBER_BITS-1:0] status_reg, status_next;
    logic [2:0]                      seen_reg, seen_next;
    logic                            named_reg, named_next;
    logic                            runne_reg, runne_next;
    logic [2:0]                      error_reg, error_next;

    logic       accept;
    logic       cr, lf, sp, dig;
    logic [7:0] c;
    logic [2:0] cls, err;
    logic       begins, held, held_m, no_result, redo;
    logic [1:0] acc_sel;
    logic [3:0] digit;

    assign accept = s_valid && s_ready;
    assign c      = s_data.data_byte;
    assign cr     = (c == hsp_pkg::CH_CR);
    assign lf     = (c == hsp_pkg::CH_LF);
    assign sp     = (c == hsp_pkg::CH_SP);
    assign dig    = (c >= hsp_pkg::CH_0) && (c <= hsp_pkg::CH_9);
    assign digit  = c[3:0];

    // Classify the byte and work out the parser state it leaves behind.
    always_comb begin
        phase_next  = phase_reg;
        kind_next   = kind_reg;
        major_next  = major_reg;
        minor_next  = minor_reg;
        status_next = status_reg;
        seen_next   = seen_reg;
        named_next  = named_reg;
        runne_next  = runne_reg;
        error_next  = error_reg;
        cls         = hsp_pkg::CLASS_OTHER;
        begins      = 1'b0;
        err         = hsp_pkg::ERR_NONE;
        held        = 1'b0;
        held_m      = 1'b0;
        no_result   = 1'b0;
        redo        = 1'b0;
        acc_sel     = ACC_NONE;

        // A restart clears the error and starts a new message.
        if (s_data.restart) begin
            error_next  = hsp_pkg::ERR_NONE;
            phase_next  = PH_TYPE;
            kind_next   = hsp_pkg::KIND_UNKNOWN;
            major_next  = '0;
            minor_next  = '0;
            status_next = '0;
            seen_next   = '0;
            named_next  = 1'b0;
            runne_next  = 1'b0;
        end

        if (error_next == hsp_pkg::ERR_NONE) begin
            // A finished head is followed by a fresh message.
            if (phase_next == PH_DONE) begin
                phase_next  = PH_TYPE;
                kind_next   = hsp_pkg::KIND_UNKNOWN;
                major_next  = '0;
                minor_next  = '0;
                status_next = '0;
                seen_next   = '0;
                named_next  = 1'b0;
                runne_next  = 1'b0;
            end
            redo = 1'b1;
            for (int i = 0; i < MAX_STEPS; i++) begin
                if (redo) begin
                    redo = 1'b0;
                    case (phase_next)
                        PH_TYPE: begin
                            if (cr || lf) begin
                            end else if (c == hsp_pkg::CH_H) begin
                                phase_next = PH_TYPECHK;
                                no_result  = 1'b1;
                            end else begin
                                kind_next  = hsp_pkg::KIND_REQUEST;
                                phase_next = PH_METHOD;
                                runne_next = 1'b0;
                                redo       = 1'b1;
                            end
                        end
                        PH_TYPECHK: begin
                            held = 1'b1;
                            if (c == hsp_pkg::CH_T) begin
                                kind_next  = hsp_pkg::KIND_RESPONSE;
                                phase_next = PH_V_T2;
                            end else if (c == hsp_pkg::CH_E) begin
                                kind_next  = hsp_pkg::KIND_REQUEST;
                                phase_next = PH_METHOD;
                                runne_next = 1'b1;
                                held_m     = 1'b1;
                                cls        = hsp_pkg::CLASS_METHOD;
                            end else begin
                                err = hsp_pkg::ERR_KIND;
                            end
                        end
                        PH_METHOD: begin
                            if (sp || cr || lf) begin
                                phase_next = PH_METHOD_SP;
                                redo       = 1'b1;
                            end else begin
                                cls        = hsp_pkg::CLASS_METHOD;
                                begins     = !runne_next;
                                runne_next = 1'b1;
                            end
                        end
                        PH_METHOD_SP: begin
                            if (sp) begin
                            end else if (cr || lf) begin
                                err = hsp_pkg::ERR_REQUEST;
                            end else begin
                                phase_next = PH_URI;
                                runne_next = 1'b0;
                                redo       = 1'b1;
                            end
                        end
                        PH_URI: begin
                            if (sp || cr || lf) begin
                                phase_next = PH_URI_SP;
                                redo       = 1'b1;
                            end else begin
                                cls        = hsp_pkg::CLASS_URI;
                                begins     = !runne_next;
                                runne_next = 1'b1;
                            end
                        end
                        PH_URI_SP: begin
                            if (sp) begin
                            end else if (cr || lf) begin
                                err = hsp_pkg::ERR_REQUEST;
                            end else begin
                                phase_next = PH_V_H;
                                redo       = 1'b1;
                            end
                        end
                        PH_V_H: begin
                            if (c != hsp_pkg::CH_H) err = hsp_pkg::ERR_VERSION;
                            else phase_next = PH_V_T1;
                        end
                        PH_V_T1: begin
                            if (c != hsp_pkg::CH_T) err = hsp_pkg::ERR_VERSION;
                            else phase_next = PH_V_T2;
                        end
                        PH_V_T2: begin
                            if (c != hsp_pkg::CH_T) err = hsp_pkg::ERR_VERSION;
                            else phase_next = PH_V_P;
                        end
                        PH_V_P: begin
                            if (c != hsp_pkg::CH_P) err = hsp_pkg::ERR_VERSION;
                            else phase_next = PH_V_SLASH;
                        end
                        PH_V_SLASH: begin
                            if (c != hsp_pkg::CH_SLASH) err = hsp_pkg::ERR_VERSION;
                            else phase_next = PH_V_MAJOR;
                        end
                        PH_V_MAJOR: begin
                            if (c == hsp_pkg::CH_DOT) begin
                                if (!seen_next[0]) err = hsp_pkg::ERR_VERSION;
                                else phase_next = PH_V_MINOR;
                            end else if (!dig) begin
                                err = hsp_pkg::ERR_VERSION;
                            end else begin
                                acc_sel      = ACC_MAJOR;
                                seen_next[0] = 1'b1;
                            end
                        end
                        PH_V_MINOR: begin
                            if (cr || lf) begin
                                if (!seen_next[1] || kind_next != hsp_pkg::KIND_REQUEST) begin
                                    err = hsp_pkg::ERR_VERSION;
                                end else begin
                                    phase_next = cr ? PH_REQ_LF : PH_HDR_START;
                                end
                            end else if (sp) begin
                                if (!seen_next[1] || kind_next != hsp_pkg::KIND_RESPONSE) begin
                                    err = hsp_pkg::ERR_VERSION;
                                end else begin
                                    phase_next = PH_RESP_SP;
                                end
                            end else if (!dig) begin
                                err = hsp_pkg::ERR_VERSION;
                            end else begin
                                acc_sel      = ACC_MINOR;
                                seen_next[1] = 1'b1;
                            end
                        end
                        PH_REQ_LF: begin
                            if (!lf) err = hsp_pkg::ERR_REQUEST;
                            else phase_next = PH_HDR_START;
                        end
                        PH_RESP_SP: begin
                            if (!sp) begin
                                phase_next = PH_STATUS;
                                redo       = 1'b1;
                            end
                        end
                        PH_STATUS: begin
                            if (cr || lf || sp) begin
                                if (!seen_next[2]) begin
                                    err = hsp_pkg::ERR_STATUS;
                                end else if (cr) begin
                                    phase_next = PH_RESP_LF;
                                end else if (lf) begin
                                    phase_next = PH_HDR_START;
                                end else begin
                                    phase_next = PH_REASON_START;
                                end
                            end else if (!dig) begin
                                err = hsp_pkg::ERR_STATUS;
                            end else begin
                                acc_sel      = ACC_STAT;
                                seen_next[2] = 1'b1;
                            end
                        end
                        PH_REASON_START: begin
                            if (!sp) begin
                                phase_next = PH_REASON;
                                runne_next = 1'b0;
                                redo       = 1'b1;
                            end
                        end
                        PH_REASON: begin
                            if (cr) begin
                                phase_next = PH_RESP_LF;
                            end else if (lf) begin
                                phase_next = PH_HDR_START;
                            end else begin
                                cls        = hsp_pkg::CLASS_REASON;
                                begins     = !runne_next;
                                runne_next = 1'b1;
                            end
                        end
                        PH_RESP_LF: begin
                            if (!lf) err = hsp_pkg::ERR_STATUS_LINE;
                            else phase_next = PH_HDR_START;
                        end
                        PH_HDR_START: begin
                            if (cr) begin
                                phase_next = PH_END_LF;
                            end else if (lf) begin
                                phase_next = PH_DONE;
                            end else if (sp) begin
                                phase_next = PH_CONT_START;
                            end else begin
                                phase_next = PH_NAME;
                                runne_next = 1'b0;
                                redo       = 1'b1;
                            end
                        end
                        PH_CONT_START: begin
                            if (!sp) begin
                                phase_next = PH_CONT;
                                runne_next = 1'b0;
                                redo       = 1'b1;
                            end
                        end
                        PH_CONT: begin
                            if (cr || lf) begin
                                if (runne_next) begin
                                    if (!named_next) err = hsp_pkg::ERR_HEADER;
                                    else phase_next = cr ? PH_HDR_LF : PH_HDR_START;
                                end else begin
                                    phase_next = cr ? PH_END_LF : PH_DONE;
                                end
                            end else begin
                                cls        = hsp_pkg::CLASS_CONT;
                                begins     = !runne_next;
                                runne_next = 1'b1;
                            end
                        end
                        PH_NAME: begin
                            if (sp || c == hsp_pkg::CH_COLON) begin
                                phase_next = PH_NAME_END;
                                redo       = 1'b1;
                            end else if (cr || lf) begin
                                err = hsp_pkg::ERR_HEADER;
                            end else begin
                                cls        = hsp_pkg::CLASS_NAME;
                                begins     = !runne_next;
                                runne_next = 1'b1;
                            end
                        end
                        PH_NAME_END: begin
                            if (runne_next) named_next = 1'b1;
                            if (sp) begin
                            end else if (c != hsp_pkg::CH_COLON || !runne_next) begin
                                err = hsp_pkg::ERR_HEADER;
                            end else begin
                                phase_next = PH_VAL_START;
                            end
                        end
                        PH_VAL_START: begin
                            if (sp) begin
                            end else if (cr) begin
                                phase_next = PH_HDR_LF;
                            end else if (lf) begin
                                phase_next = PH_HDR_START;
                            end else begin
                                phase_next = PH_VAL;
                                runne_next = 1'b0;
                                redo       = 1'b1;
                            end
                        end
                        PH_VAL: begin
                            if (cr) begin
                                phase_next = PH_HDR_LF;
                            end else if (lf) begin
                                phase_next = PH_HDR_START;
                            end else begin
                                cls        = hsp_pkg::CLASS_VALUE;
                                begins     = !runne_next;
                                runne_next = 1'b1;
                            end
                        end
                        PH_HDR_LF: begin
                            if (!lf) err = hsp_pkg::ERR_HEADER;
                            else phase_next = PH_HDR_START;
                        end
                        PH_END_LF: begin
                            if (!lf) err = hsp_pkg::ERR_HEADER;
                            else phase_next = PH_DONE;
                        end
                        default: begin
                            // An unknown phase restarts the message.
                            phase_next  = PH_TYPE;
                            kind_next   = hsp_pkg::KIND_UNKNOWN;
                            major_next  = '0;
                            minor_next  = '0;
                            status_next = '0;
                            seen_next   = '0;
                            named_next  = 1'b0;
                            runne_next  = 1'b0;
                            redo        = 1'b1;
                        end
                    endcase
                end
            end

            // At most one digit is taken per byte.
            case (acc_sel)
                ACC_MAJOR: major_next  = hsp_pkg::dec_acc(major_next, digit);
                ACC_MINOR: minor_next  = hsp_pkg::dec_acc(minor_next, digit);
                ACC_STAT:  status_next = hsp_pkg::dec_acc(status_next, digit);
                default: begin
                end
            endcase

            // The byte that raises an error is tagged as other.
            if (err != hsp_pkg::ERR_NONE) begin
                error_next = err;
                cls        = hsp_pkg::CLASS_OTHER;
                begins     = 1'b0;
                held_m     = 1'b0;
            end
        end
    end

    // Queue entry for the byte.
    always_comb begin
        push_entry.byte_value    = c;
        push_entry.byte_class    = cls;
        push_entry.field_begins  = begins;
        push_entry.message_kind  = kind_next;
        push_entry.major_version = hsp_pkg::OUT_NUM_BITS'(major_next);
        push_entry.minor_version = hsp_pkg::OUT_NUM_BITS'(minor_next);
        push_entry.status_code   = hsp_pkg::OUT_NUM_BITS'(status_next);
        push_entry.head_complete = (phase_next == PH_DONE);
        push_entry.error_kind    = error_next;
        push_entry.held          = held;
        push_entry.held_method   = held_m;
    end

    assign push = accept && !no_result;

    // Parser state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_TYPE;
            kind_reg   <= hsp_pkg::KIND_UNKNOWN;
            major_reg  <= '0;
            minor_reg  <= '0;
            status_reg <= '0;
            seen_reg   <= '0;
            named_reg  <= 1'b0;
            runne_reg  <= 1'b0;
            error_reg  <= hsp_pkg::ERR_NONE;
        end else if (accept) begin
            phase_reg  <= phase_next;
            kind_reg   <= kind_next;
            major_reg  <= major_next;
            minor_reg  <= minor_next;
            status_reg <= status_next;
            seen_reg   <= seen_next;
            named_reg  <= named_next;
            runne_reg  <= runne_next;
            error_reg  <= error_next;
        end
    end

    // While an error stands, bytes without restart leave the parser alone.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && error_reg != hsp_pkg::ERR_NONE && !s_data.restart)
        |=> ($stable(phase_reg) && $stable(error_reg) && $stable(kind_reg)))
        else $error("parser state changed while in error");

    // Only a byte arriving in the leading-H check phase releases a held H.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (push && push_entry.held) |-> (phase_reg == PH_TYPECHK && !s_data.restart))
        else $error("held H released outside the check phase");

endmodule

>>> hw/rtl/hsp_queue.sv
module hsp_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  hsp_pkg::hsp_entry_t push_entry,
    input  logic                pop,
    output hsp_pkg::hsp_entry_t head_entry,
    output hsp_pkg::hsp_qstat_t qstat
);

    hsp_pkg::hsp_entry_t              slots_reg [hsp_pkg::QUEUE_DEPTH];
    logic [hsp_pkg::QPTR_BITS-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [hsp_pkg::QCNT_BITS-1:0]    count_reg;

    localparam logic [hsp_pkg::QPTR_BITS-1:0] LAST_SLOT =
        hsp_pkg::QPTR_BITS'(hsp_pkg::QUEUE_DEPTH - 1);
    localparam logic [hsp_pkg::QCNT_BITS-1:0] FULL_COUNT =
        hsp_pkg::QCNT_BITS'(hsp_pkg::QUEUE_DEPTH);

    assign qstat.empty = (count_reg == '0);
    assign qstat.full  = (count_reg == FULL_COUNT);
    assign head_entry  = slots_reg[rd_ptr_reg];

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn) push |-> !qstat.full)
        else $error("queue overflow");

    assert property (@(posedge aclk) disable iff (!aresetn) pop |-> !qstat.empty)
        else $error("queue underflow");

endmodule

>>> hw/rtl/hsp_back.sv
module hsp_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  hsp_pkg::hsp_entry_t head_entry,
    input  hsp_pkg::hsp_qstat_t qstat,
    output logic                pop,
    output logic                m_valid,
    input  logic                m_ready,
    output hsp_pkg::hsp_out_t   m_data
);

    logic              m_valid_reg;
    hsp_pkg::hsp_out_t m_data_reg, m_data_next;
    logic              half_reg;
    logic              load, first_half;

    assign load       = !qstat.empty && (!m_valid_reg || m_ready);
    assign first_half = head_entry.held && !half_reg;
    assign pop        = load && !first_half;

    // Build the result; a held H goes out ahead of the byte that released it.
    always_comb begin
        m_data_next.message_kind  = head_entry.message_kind;
        m_data_next.major_version = head_entry.major_version;
        m_data_next.minor_version = head_entry.minor_version;
        m_data_next.status_code   = head_entry.status_code;
        m_data_next.head_complete = head_entry.head_complete;
        m_data_next.parse_error   = (head_entry.error_kind != hsp_pkg::ERR_NONE);
        m_data_next.error_kind    = head_entry.error_kind;
        if (first_half) begin
            m_data_next.byte_value   = hsp_pkg::CH_H;
            m_data_next.byte_class   = head_entry.held_method ? hsp_pkg::CLASS_METHOD
                                                              : hsp_pkg::CLASS_OTHER;
            m_data_next.field_begins = head_entry.held_method;
            m_data_next.last         = 1'b0;
        end else begin
            m_data_next.byte_value   = head_entry.byte_value;
            m_data_next.byte_class   = head_entry.byte_class;
            m_data_next.field_begins = head_entry.field_begins;
            m_data_next.last         = 1'b1;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            half_reg    <= 1'b0;
        end else begin
            if (load) begin
                m_valid_reg <= 1'b1;
                half_reg    <= first_half;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // The second half of a split entry is still at the queue head.
    assert property (@(posedge aclk) disable iff (!aresetn)
        half_reg |-> (!qstat.empty && head_entry.held))
        else $error("split entry lost from the queue head");

endmodule

>>> hw/rtl/http_start_line_header_parser_core.sv
// HTTP/1.x message head tokenizer. It takes one byte per clock on the s_ channel
// while the queue is not full and returns each byte on the m_ channel tagged with its
// field class, the message kind, the version and status numbers parsed so far
// (decimal, saturating at all ones), the end-of-head mark and a sticky error code;
// restart clears the error and starts a new message before its byte. A leading H is
// held back and gives no result on its own; the byte after it then gives two results,
// the H first. The parser is combinational and writes the classified byte into the
// queue when it is accepted, and the output register then loads it from the queue
// head. The output register sustains one result per cycle while m_ready is high, so
// input runs at one byte per cycle except that a byte releasing a held H needs two
// output results. A four-entry queue between the parser and the output stage absorbs
// those extra results and output stalls. The block needs no clearing pass after reset.
module http_start_line_header_parser_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  hsp_pkg::hsp_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output hsp_pkg::hsp_out_t m_data
);

    logic                push, pop;
    hsp_pkg::hsp_entry_t push_entry, head_entry;
    hsp_pkg::hsp_qstat_t qstat;

    assign s_ready = !qstat.full;

    hsp_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .push       (push),
        .push_entry (push_entry)
    );

    hsp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_entry (head_entry),
        .qstat      (qstat)
    );

    hsp_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_entry (head_entry),
        .qstat      (qstat),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule
